FILE: src/sbl_pkg.sv
// ----------------------------------------------------------------------------
// sbl_pkg: shared types and constants for the spectrum bar level block
// Holds the item and result payloads, the controller states, the command and
// status groups between controller and datapath, and the fixed-point
// constants of the level arithmetic.
// ----------------------------------------------------------------------------
package sbl_pkg;

  // Display geometry.
  localparam int BANK_COUNT   = 256;
  localparam int BAR_ROWS     = 256;
  localparam int PALETTE_SIZE = 256;

  // Amplitude scale, Q1.15.
  localparam logic [15:0] AMP_ONE   = 16'd32768;
  localparam logic [15:0] REF_FLOOR = 16'd32;
  localparam int          GAIN      = 48;
  localparam int          SCALED_W  = 21;
  localparam logic [10:0] DECAY_Q16 = 11'd1311;

  // Ratio divider: 40-bit dividend, four quotient bits per step.
  localparam int NUM_W      = 40;
  localparam int DIV_DIGITS = 4;
  localparam int DIV_STEPS  = NUM_W / DIV_DIGITS;
  localparam int Q_W        = 32;
  localparam int REM_W      = 16;

  // Logarithm: one fraction bit per squaring.
  localparam int LOG_STEPS = 16;
  localparam int MANT_W    = 31;
  localparam int L_W       = 20;
  localparam int STEP_W    = $clog2(LOG_STEPS);

  // Height = floor(L * BAR_ROWS / round(log2(48) * 2^16)), done as a
  // multiplication by a rounded-up reciprocal, which is exact for L < 2^20.
  localparam longint LOG2_GAIN_Q16 = 366016;
  localparam int     H_SHIFT       = 40;
  localparam longint H_RECIP       =
    ((longint'(1) << H_SHIFT) * BAR_ROWS + LOG2_GAIN_Q16 - 1) / LOG2_GAIN_Q16;
  localparam int     HRAW_W        =
    $clog2(((longint'(1) << L_W) * BAR_ROWS) / LOG2_GAIN_Q16 + 1);
  localparam int     HPROD_W       = H_SHIFT + HRAW_W;
  localparam int     HGT_W         = $clog2(BAR_ROWS);

  // Colour = floor(height * PALETTE_SIZE / BAR_ROWS), same technique.
  localparam int     C_SHIFT = 32;
  localparam longint C_RECIP =
    ((longint'(1) << C_SHIFT) * PALETTE_SIZE + BAR_ROWS - 1) / BAR_ROWS;
  localparam int     CPROD_W = C_SHIFT + 8;

  typedef struct packed {
    logic [15:0] amplitude;
    logic        last_bank;
  } item_t;

  typedef struct packed {
    logic [7:0] bank_index;
    logic [7:0] bar_height;
    logic [7:0] waterfall_color;
    logic       frame_end;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_LZ,
    ST_NORM,
    ST_LOG,
    ST_HGT,
    ST_SAT,
    ST_COL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic lz;
    logic norm;
    logic log_step;
    logic hgt;
    logic sat;
    logic col;
    logic out_write;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } status_t;

endpackage

FILE: src/sbl_ctrl.sv
// ----------------------------------------------------------------------------
// sbl_ctrl: sequencer for the spectrum bar level block
// Steps one item through division, normalisation, logarithm, height and
// colour scaling, and hands the result to the output register.
// ----------------------------------------------------------------------------
module sbl_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  sbl_pkg::status_t status,
  output sbl_pkg::cmd_t    cmd,
  output logic            busy
);
  import sbl_pkg::*;

  state_t             state;
  state_t             state_next;
  logic [STEP_W-1:0]  step;
  logic               last_div;
  logic               last_log;

  assign last_div = (step == STEP_W'(DIV_STEPS - 1));
  assign last_log = (step == STEP_W'(LOG_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state_next != state) begin
        step <= '0;
      end else begin
        step <= step + STEP_W'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (item_valid) state_next = ST_DIV;
      ST_DIV:  if (last_div) state_next = ST_LZ;
      ST_LZ:   state_next = ST_NORM;
      ST_NORM: state_next = ST_LOG;
      ST_LOG:  if (last_log) state_next = ST_HGT;
      ST_HGT:  state_next = ST_SAT;
      ST_SAT:  state_next = ST_COL;
      ST_COL:  state_next = ST_OUT;
      ST_OUT:  if (!status.out_full) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = item_valid;
      end
      ST_DIV:  cmd.div_step = 1'b1;
      ST_LZ:   cmd.lz = 1'b1;
      ST_NORM: cmd.norm = 1'b1;
      ST_LOG:  cmd.log_step = 1'b1;
      ST_HGT:  cmd.hgt = 1'b1;
      ST_SAT:  cmd.sat = 1'b1;
      ST_COL:  cmd.col = 1'b1;
      ST_OUT:  cmd.out_write = !status.out_full;
      default: cmd = '0;
    endcase
  end

endmodule

FILE: src/sbl_datapath.sv
// ----------------------------------------------------------------------------
// sbl_datapath: arithmetic and state of the spectrum bar level block
// Holds the bank counter, frame peak and reference level, the ratio divider,
// the logarithm unit, the height and colour scaling and the output register.
// ----------------------------------------------------------------------------
module sbl_datapath (
  input  logic              clk,
  input  logic              rst,
  input  sbl_pkg::cmd_t     cmd,
  output sbl_pkg::status_t  status,
  input  sbl_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_stall,
  output sbl_pkg::result_t  result
);
  import sbl_pkg::*;

  // Frame state.
  logic [7:0]          bank_counter;
  logic [15:0]         frame_peak;
  logic [15:0]         reference;

  // Item in flight.
  logic [7:0]          item_index;
  logic                item_last;
  logic [NUM_W-1:0]    num;
  logic [REM_W-1:0]    rem;
  logic [Q_W-1:0]      quot;
  logic [4:0]          top_pos;
  logic                below_one;
  logic [MANT_W-1:0]   mant;
  logic [15:0]         frac;
  logic [HPROD_W-1:0]  hprod;
  logic [HGT_W-1:0]    height;
  logic [CPROD_W-1:0]  cprod;

  // Combinational helpers.
  logic [15:0]         amp_sat;
  logic [SCALED_W-1:0] scaled;
  logic [8:0]          bc_inc;
  logic [7:0]          bc_next;
  logic [REM_W-1:0]    div_rem;
  logic [NUM_W-1:0]    div_num;
  logic [REM_W:0]      trial;
  logic [DIV_DIGITS-1:0] qbits;
  logic [4:0]          top_found;
  logic [26:0]         decay_prod;
  logic [15:0]         ref_upd;
  logic [Q_W-1:0]      norm_val;
  logic [2*MANT_W-1:0] sq;
  logic [Q_W-1:0]      sqt;
  logic [L_W-1:0]      log_val;
  logic [HRAW_W-1:0]   hraw;
  logic [HGT_W-1:0]    hsat;
  logic [7:0]          bar;

  assign amp_sat = (item.amplitude > AMP_ONE) ? AMP_ONE : item.amplitude;
  assign scaled  = SCALED_W'(amp_sat) * SCALED_W'(GAIN);
  assign bc_inc  = {1'b0, bank_counter} + 9'd1;
  assign bc_next = (32'(bc_inc) >= BANK_COUNT) ? 8'd0 : bc_inc[7:0];

  // Restoring division, four quotient bits per step. The partial remainder
  // stays below the reference, so it fits in sixteen bits.
  always_comb begin
    div_rem = rem;
    div_num = num;
    qbits   = '0;
    trial   = '0;
    for (int i = 0; i < DIV_DIGITS; i++) begin
      trial   = {div_rem, div_num[NUM_W-1]};
      div_num = div_num << 1;
      if (trial >= {1'b0, reference}) begin
        div_rem                 = REM_W'(trial - {1'b0, reference});
        qbits[DIV_DIGITS-1-i]   = 1'b1;
      end else begin
        div_rem = REM_W'(trial);
      end
    end
  end

  // Top set bit of the ratio; only the upper half matters, since a ratio
  // below one gives no bar at all.
  always_comb begin
    top_found = 5'd16;
    for (int i = 0; i < 16; i++) begin
      if (quot[16+i]) top_found = 5'(16 + i);
    end
  end

  // Reference follows the frame peak upwards and decays by 2 percent.
  always_comb begin
    decay_prod = 27'(reference) * 27'(DECAY_Q16);
    if (reference < frame_peak) begin
      ref_upd = frame_peak;
    end else begin
      ref_upd = reference - 16'(decay_prod[26:16]);
    end
    if (ref_upd < REF_FLOOR) ref_upd = REF_FLOOR;
  end

  assign norm_val = quot << (5'd31 - top_pos);
  assign sq       = (2*MANT_W)'(mant) * (2*MANT_W)'(mant);
  assign sqt      = sq[2*MANT_W-1:MANT_W-1];
  assign log_val  = {4'(top_pos - 5'd16), frac};
  assign hraw     = hprod[H_SHIFT +: HRAW_W];
  assign hsat     = (32'(hraw) >= BAR_ROWS) ? HGT_W'(BAR_ROWS - 1) : HGT_W'(hraw);
  assign bar      = (32'(height) > 255) ? 8'hFF : 8'(height);

  // Frame state.
  always_ff @(posedge clk) begin
    if (rst) begin
      bank_counter <= '0;
      frame_peak   <= '0;
      reference    <= REF_FLOOR;
    end else begin
      if (cmd.load) begin
        if (amp_sat > frame_peak) frame_peak <= amp_sat;
        bank_counter <= item.last_bank ? 8'd0 : bc_next;
      end
      if (cmd.lz && item_last) begin
        reference  <= ref_upd;
        frame_peak <= '0;
      end
    end
  end

  // Working registers of the item in flight.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_index <= bank_counter;
      item_last  <= item.last_bank;
      num        <= NUM_W'({scaled, 16'd0});
      rem        <= '0;
    end
    if (cmd.div_step) begin
      num  <= div_num;
      rem  <= div_rem;
      quot <= {quot[Q_W-DIV_DIGITS-1:0], qbits};
    end
    if (cmd.lz) begin
      top_pos   <= top_found;
      below_one <= (quot[31:16] == 16'd0);
    end
    if (cmd.norm) begin
      mant <= norm_val[Q_W-1:1];
      frac <= '0;
    end
    if (cmd.log_step) begin
      mant <= sqt[Q_W-1] ? sqt[Q_W-1:1] : sqt[Q_W-2:0];
      frac <= {frac[14:0], sqt[Q_W-1]};
    end
    if (cmd.hgt) hprod <= HPROD_W'(log_val) * HPROD_W'(H_RECIP);
    if (cmd.sat) height <= below_one ? '0 : hsat;
    if (cmd.col) cprod <= CPROD_W'(height) * CPROD_W'(C_RECIP);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_write) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_write) begin
      result.bank_index      <= item_index;
      result.bar_height      <= bar;
      result.waterfall_color <= cprod[C_SHIFT +: 8];
      result.frame_end       <= item_last;
    end
  end

  assign status.out_full = result_valid && result_stall;

endmodule

FILE: src/spectrum_bar_level_agc.sv
// ----------------------------------------------------------------------------
// spectrum_bar_level_agc: log-scaled bar meter level with peak/decay AGC
// Turns one spectrum bank amplitude into a bar height and waterfall palette
// index, tracking a reference level from frame to frame.
// ----------------------------------------------------------------------------
// Each transfer on the item channel carries one bank amplitude (Q1.15, values
// above 1.0 count as 1.0) and a last-bank mark; each yields exactly one
// transfer on the result channel with the bank index, bar height, palette
// index and frame-end mark. Items are worked one at a time: each passes through
// ten steps of the ratio divider (four quotient bits a step) and sixteen
// squarings of the logarithm multiplier, plus normalising, scaling and
// hand-over. The output register lets the next item be taken while a result
// still waits on a stalled consumer. The reference level starts at 1/1024
// after reset and is updated once per frame, after the bank carrying the
// last-bank mark.
// ----------------------------------------------------------------------------
module spectrum_bar_level_agc (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  sbl_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output sbl_pkg::result_t result
);
  import sbl_pkg::*;

  // Commands flow from the sequencer to the datapath; the only status back
  // is whether the output register can take a new result this cycle.
  cmd_t    cmd;
  status_t status;
  logic    busy;

  sbl_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .status     (status),
    .cmd        (cmd),
    .busy       (busy)
  );

  sbl_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // A new item is taken only while the sequencer is idle.
  assign item_stall = busy;

endmodule

FILE: src/sbl_checker.sv
// ----------------------------------------------------------------------------
// sbl_checker: port-level checks for the spectrum bar level block
// Watches the item and result channels and checks ordering and consistency
// of the transfers over time.
// ----------------------------------------------------------------------------
module sbl_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_stall,
  input sbl_pkg::item_t   item,
  input logic             result_valid,
  input logic             result_stall,
  input sbl_pkg::result_t result
);
  import sbl_pkg::*;

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] pending;
  logic       seen_end;

  assign in_xfer  = item_valid && !item_stall;
  assign out_xfer = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending  <= '0;
      seen_end <= 1'b0;
    end else begin
      pending <= pending + 2'(in_xfer) - 2'(out_xfer);
      if (out_xfer) seen_end <= result.frame_end;
    end
  end

  // A result waiting on a stall is held unchanged.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // At most one item in work and one waiting; no result without an item.
  a_pending: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3 && (!result_valid || pending != 2'd0))
    else $error("result count does not match item count");

  // With one result waiting and one item in work, no further item is taken.
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    pending == 2'd2 |-> item_stall)
    else $error("item taken while two are outstanding");

  // The bank after a frame end starts a new frame.
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    result_valid && seen_end |-> result.bank_index == 8'd0)
    else $error("bank index not reset after frame end");

  // An empty bar maps to the first palette entry.
  a_zero_colour: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.bar_height == 8'd0 |-> result.waterfall_color == 8'd0)
    else $error("non-zero colour for empty bar");

endmodule

bind spectrum_bar_level_agc sbl_checker u_sbl_checker (.*);

FILE: sim/spectrum_bar_level_agc_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectrum_bar_level_agc_tb: self-checking bench for the spectrum bar meter
// Drives bank amplitudes with last-bank marks through the item channel and
// compares every result transfer with a typed table row or a bit-exact
// software level meter that tracks bank count, frame peak and reference.
// ----------------------------------------------------------------------------
module spectrum_bar_level_agc_tb;
  import sbl_pkg::item_t;
  import sbl_pkg::result_t;

  // Geometry and fixed-point constants of the meter, kept local so that the
  // prediction does not lean on the design's own package arithmetic.
  localparam int          BANKS       = 256;
  localparam int          ROWS        = 256;
  localparam int          PALETTE     = 256;
  localparam logic [15:0] AMP_FULL    = 16'd32768;
  localparam logic [15:0] REF_MIN     = 16'd32;
  localparam longint      GAIN_48     = 48;
  localparam longint      LOG2_48_Q16 = 366016;
  localparam longint      DECAY_Q16   = 1311;

  // Wait at the end of the run, after the last result has been transferred.
  localparam int DRAIN_CYCLES = 40;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_stall;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  always #4 clk = ~clk;

  spectrum_bar_level_agc u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // --------------------------------------------------------------------------
  // Level meter prediction
  // --------------------------------------------------------------------------
  // The bench's own copy of the meter state: position within the frame,
  // the largest saturated amplitude seen in this frame, and the reference.
  int          bank_pos;
  logic [15:0] peak_amp;
  logic [15:0] ref_amp;

  result_t pending_bars[$];
  int      fail_count = 0;

  // log2 of a Q.16 ratio of at least 1.0, returned in Q.16. The integer part
  // is the top set bit's position less 16; each fraction bit comes from squaring
  // a Q1.30 mantissa and halving it whenever the square reaches 2.0.
  function automatic logic [19:0] log2_q16(input logic [63:0] ratio);
    int          top;
    logic [63:0] mant;
    logic [19:0] lg;
    top = 0;
    for (int b = 0; b < 64; b++) if (ratio[b]) top = b;
    if (top >= 30) mant = ratio >> (top - 30);
    else mant = ratio << (30 - top);
    lg = {4'(top - 16), 16'd0};
    for (int k = 15; k >= 0; k--) begin
      mant = (mant * mant) >> 30;
      if (mant >= 64'h8000_0000) begin
        lg[k] = 1'b1;
        mant = mant >> 1;
      end
    end
    return lg;
  endfunction

  // Works out the result of one bank and advances the meter state.
  function automatic result_t meter_step(input item_t it);
    logic [15:0] amp;
    logic [15:0] divisor;
    logic [15:0] next_ref;
    logic [63:0] ratio;
    logic [63:0] height;
    logic [63:0] colour;
    result_t     bar;
    amp = (it.amplitude > AMP_FULL) ? AMP_FULL : it.amplitude;
    if (amp > peak_amp) peak_amp = amp;
    divisor = (ref_amp == 16'd0) ? 16'd1 : ref_amp;
    ratio   = (64'(amp) * 64'(GAIN_48)) << 16;
    ratio   = ratio / 64'(divisor);
    height  = '0;
    if (ratio >= 64'd65536) begin
      height = 64'(log2_q16(ratio)) * 64'(ROWS) / 64'(LOG2_48_Q16);
      if (height >= 64'(ROWS)) height = 64'(ROWS - 1);
    end
    colour = height * 64'(PALETTE) / 64'(ROWS);

    bar.bank_index      = 8'(bank_pos);
    bar.bar_height      = (height > 64'd255) ? 8'd255 : height[7:0];
    bar.waterfall_color = (colour > 64'd255) ? 8'd255 : colour[7:0];
    bar.frame_end       = it.last_bank;

    if (it.last_bank) begin
      // The reference jumps up to a larger frame peak, otherwise decays by
      // about two percent, and never drops under 1/1024.
      next_ref = ref_amp;
      if (next_ref < peak_amp) next_ref = peak_amp;
      else next_ref = next_ref - 16'((64'(next_ref) * 64'(DECAY_Q16)) >> 16);
      if (next_ref < REF_MIN) next_ref = REF_MIN;
      ref_amp  = next_ref;
      peak_amp = '0;
      bank_pos = 0;
    end else begin
      bank_pos = (bank_pos + 1 >= BANKS) ? 0 : (bank_pos + 1) % 256;
    end
    return bar;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  // A result transfer happens at an edge where valid is high and stall is
  // low. Both are read just after the edge, before any nonblocking update of
  // that step lands, so the values seen are the ones the edge acted on.
  always @(posedge clk) begin : check_bars
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_bars.size() == 0) begin
        $error("unexpected result transfer: bank_index %0d bar_height %0d",
               result.bank_index, result.bar_height);
        fail_count++;
      end else begin
        want = pending_bars.pop_front();
        if (result.bank_index !== want.bank_index) begin
          $error("bank_index: expected %0d, got %0d", want.bank_index, result.bank_index);
          fail_count++;
        end
        if (result.bar_height !== want.bar_height) begin
          $error("bar_height: expected %0d, got %0d", want.bar_height, result.bar_height);
          fail_count++;
        end
        if (result.waterfall_color !== want.waterfall_color) begin
          $error("waterfall_color: expected %0d, got %0d",
                 want.waterfall_color, result.waterfall_color);
          fail_count++;
        end
        if (result.frame_end !== want.frame_end) begin
          $error("frame_end: expected %0d, got %0d", want.frame_end, result.frame_end);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Consumer stall pattern
  // --------------------------------------------------------------------------
  // Each time the 8-bit cycle counter wraps, the consumer picks a new
  // behaviour: flowing freely, stalling on scattered single cycles, or holding
  // off for long stretches. This moves the stalls across every phase of the
  // design's work, including while a finished result waits in its register.
  logic [7:0] stall_cycle = '0;
  int         stall_mode  = 0;
  int         stall_hold  = 0;

  always @(posedge clk) begin
    if (rst) begin
      stall_cycle  <= '0;
      stall_mode   <= 0;
      stall_hold   <= 0;
      result_stall <= 1'b0;
    end else begin
      stall_cycle <= stall_cycle + 8'd1;
      if (stall_cycle == 8'hFF) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        1: begin
          result_stall <= ($urandom_range(0, 3) == 0);
        end
        2: begin
          if (stall_hold > 0) begin
            stall_hold   <= stall_hold - 1;
            result_stall <= 1'b1;
          end else if ($urandom_range(0, 7) == 0) begin
            stall_hold   <= $urandom_range(1, 19);
            result_stall <= 1'b1;
          end else begin
            result_stall <= 1'b0;
          end
        end
        default: begin
          result_stall <= 1'b0;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Bank sender
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int banks_sent = 0;

  // Offers one bank and waits for its transfer. The expectation is queued
  // once the transfer has happened; the payload holds still while stalled.
  // Between bursts of random length the sender often drops valid.
  task automatic send_bank(input item_t it, input bit typed, input result_t typed_bar);
    result_t predicted;
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predicted = meter_step(it);
    pending_bars.push_back(typed ? typed_bar : predicted);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if ($urandom_range(0, 3) != 0) begin
        item_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  // A spread of amplitudes: silence, values above full scale, plain random
  // words, and random words shifted down so that small and mid levels, where
  // the logarithm does most of its work, turn up often.
  function automatic logic [15:0] random_amp();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 16'd0;
    if (pick == 1) return 16'($urandom_range(32769, 65535));
    if (pick <= 3) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(0, 65535) >> $urandom_range(1, 14));
  endfunction

  // Short frames of random length. About one frame in five is quiet, so that
  // its peak stays under the reference and the decay path is taken.
  task automatic send_frames(input int upto);
    int    len;
    bit    quiet;
    item_t it;
    while (banks_sent < upto) begin
      len   = $urandom_range(1, 16);
      quiet = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < len; i++) begin
        it.amplitude = quiet ? (random_amp() >> 8) : random_amp();
        it.last_bank = (i == len - 1);
        send_bank(it, 1'b0, '0);
        banks_sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  // Rows marked typed carry a result that follows directly from the state:
  // silence after reset, saturation at the top row for full-scale input
  // against the 1/1024 reset reference, and the ratio just under one once the
  // reference has followed a full-scale peak. The rest go to the predictor.
  typedef struct packed {
    item_t   stim;
    bit      typed;
    result_t bar;
  } dir_row_t;

  localparam int DIR_ROWS = 21;
  localparam dir_row_t DIR_TBL [DIR_ROWS] = '{
    '{'{16'd0,     1'b0}, 1'b1, '{8'd0, 8'd0,   8'd0,   1'b0}},
    '{'{16'hFFFF,  1'b0}, 1'b1, '{8'd1, 8'd255, 8'd255, 1'b0}},
    '{'{16'd32768, 1'b0}, 1'b1, '{8'd2, 8'd255, 8'd255, 1'b0}},
    '{'{16'd32769, 1'b0}, 1'b1, '{8'd3, 8'd255, 8'd255, 1'b0}},
    '{'{16'd1,     1'b0}, 1'b0, '0},
    '{'{16'h5555,  1'b0}, 1'b0, '0},
    '{'{16'hAAAA,  1'b0}, 1'b0, '0},
    // Frame end: the reference follows the full-scale peak up.
    '{'{16'd0,     1'b1}, 1'b1, '{8'd7, 8'd0,   8'd0,   1'b1}},
    '{'{16'd32768, 1'b0}, 1'b1, '{8'd0, 8'd255, 8'd255, 1'b0}},
    '{'{16'd682,   1'b0}, 1'b1, '{8'd1, 8'd0,   8'd0,   1'b0}},
    '{'{16'd683,   1'b0}, 1'b0, '0},
    // Frame end with a peak equal to the reference: decay instead.
    '{'{16'd0,     1'b1}, 1'b1, '{8'd3, 8'd0,   8'd0,   1'b1}},
    '{'{16'd683,   1'b0}, 1'b0, '0},
    '{'{16'd16384, 1'b0}, 1'b0, '0},
    '{'{16'd4096,  1'b0}, 1'b0, '0},
    '{'{16'h00FF,  1'b0}, 1'b0, '0},
    '{'{16'h7FFF,  1'b1}, 1'b0, '0},
    '{'{16'd100,   1'b1}, 1'b0, '0},
    '{'{16'hFFFF,  1'b1}, 1'b0, '0},
    '{'{16'd0,     1'b1}, 1'b0, '0},
    '{'{16'd0,     1'b0}, 1'b0, '0}
  };

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : run
    item_t it;
    bank_pos = 0;
    peak_amp = '0;
    ref_amp  = REF_MIN;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIR_ROWS; r++) send_bank(DIR_TBL[r].stim, DIR_TBL[r].typed,
                                                 DIR_TBL[r].bar);

    // Hold the sender back until every directed result has been transferred,
    // so that the design drains completely once mid-run.
    item_valid <= 1'b0;
    while (pending_bars.size() != 0) @(posedge clk);

    send_frames(130);

    // One long stretch with no last-bank mark: the bank index runs past 255
    // and wraps, and the peak keeps building across the whole stretch.
    for (int i = 0; i < 270; i++) begin
      it.amplitude = random_amp();
      it.last_bank = 1'b0;
      send_bank(it, 1'b0, '0);
      banks_sent++;
    end

    send_frames(480);

    item_valid <= 1'b0;
    while (pending_bars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Far above the slowest correct run: about 500 banks worked one at a time,
  // plus sender gaps and consumer stalls.
  initial begin : watchdog
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
